FILE: hw/rtl/ffa_pkg.sv
// Shared widths and types for the first-fit free-list allocator.
// Used by ffa_alu, ffa_ctrl and first_fit_free_list_allocator_top; no dependencies.
package ffa_pkg;

  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 33;
  localparam int REQ_W      = 32;
  localparam int OPND_W     = 49;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  // Request to the shared adder: a + b, or a - b when sub is set.
  typedef struct packed {
    logic              sub;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
  } alu_req_t;

  // ge is the carry out, which means a >= b for a subtraction.
  typedef struct packed {
    logic [OPND_W-1:0] result;
    logic              ge;
  } alu_res_t;

  // Configuration as seen by the sequencer. reload pulses on a write to a mapped register.
  typedef struct packed {
    logic [ADDR_W-1:0] heap_limit;
    logic              heap_enable;
    logic              reload;
    logic [ADDR_W-1:0] reload_base;
  } cfg_t;

endpackage

FILE: hw/rtl/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
  parameter int WIDTH = 81,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ffa_alu.sv
// Shared 49-bit adder/subtractor with a compare flag.
// Depends on ffa_pkg.
module ffa_alu (
  input  ffa_pkg::alu_req_t req,
  output ffa_pkg::alu_res_t res
);
  import ffa_pkg::*;

  logic [OPND_W:0] total;

  // One carry chain serves add, subtract and the unsigned compare.
  assign total = {1'b0, req.a} + {1'b0, req.b ^ {OPND_W{req.sub}}}
               + {{OPND_W{1'b0}}, req.sub};

  assign res.result = total[OPND_W-1:0];
  assign res.ge     = total[OPND_W];

endmodule

FILE: hw/rtl/ffa_ctrl.sv
// Sequencer, free-block table and bump pointer of the allocator.
// Depends on ffa_pkg, ffa_ram and ffa_alu.
module ffa_ctrl #(
  parameter int FREE_DEPTH   = 16,
  parameter int HEADER_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ffa_pkg::cfg_t                 cfg,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic [ffa_pkg::REQ_W-1:0]     request_size,
  input  logic [ffa_pkg::ADDR_W-1:0]    user_address,
  input  logic [ffa_pkg::SIZE_W-1:0]    freed_block_size,
  output logic                          done,
  output logic [ffa_pkg::ADDR_W-1:0]    granted_address,
  output logic [ffa_pkg::SIZE_W-1:0]    granted_size,
  output logic [2:0]                    status
);
  import ffa_pkg::*;

  localparam int IDX_W   = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(FREE_DEPTH + 1);
  localparam int PTR_W   = IDX_W + 1;
  localparam int ENTRY_W = ADDR_W + SIZE_W;

  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(FREE_DEPTH);
  localparam logic [OPND_W-1:0] HDR_OPND   = OPND_W'(HEADER_BYTES);
  localparam logic [OPND_W-1:0] ROUND_OPND = OPND_W'(HEADER_BYTES + 7);

  localparam logic CMD_FREE = 1'b1;

  localparam logic [2:0] STAT_REUSED   = 3'd0;
  localparam logic [2:0] STAT_BUMP     = 3'd1;
  localparam logic [2:0] STAT_NOMEM    = 3'd2;
  localparam logic [2:0] STAT_DISABLED = 3'd3;
  localparam logic [2:0] STAT_FREED    = 3'd4;
  localparam logic [2:0] STAT_IGNORED  = 3'd5;
  localparam logic [2:0] STAT_FULL     = 3'd6;

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_DECODE     = 3'd1;
  localparam logic [2:0] ST_SCAN       = 3'd2;
  localparam logic [2:0] ST_REUSE      = 3'd3;
  localparam logic [2:0] ST_SHIFT      = 3'd4;
  localparam logic [2:0] ST_BUMP_ADD   = 3'd5;
  localparam logic [2:0] ST_BUMP_CHK   = 3'd6;
  localparam logic [2:0] ST_BUMP_GRANT = 3'd7;

  logic [2:0]        state;
  logic              cmd;
  logic [REQ_W-1:0]  req;
  logic [ADDR_W-1:0] uaddr;
  logic [SIZE_W-1:0] fsize;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] bump;
  logic [SIZE_W-1:0] needed;
  logic [OPND_W-1:0] bump_sum;
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  mv_idx;
  logic [ADDR_W-1:0] blk_base;
  logic [SIZE_W-1:0] blk_bytes;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ADDR_W-1:0]  rd_base;
  logic [SIZE_W-1:0]  rd_bytes;
  alu_req_t           alu_req;
  alu_res_t           alu_res;

  logic [CNT_W-1:0] count_dec;
  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] free_slot;
  logic [IDX_W-1:0] scan_prev;
  logic [PTR_W-1:0] hit_next;
  logic [PTR_W-1:0] mv_next1;
  logic [PTR_W-1:0] mv_next2;
  logic             free_ok;

  assign busy      = (state != ST_IDLE);
  assign count_dec = count - CNT_W'(1);
  assign top_idx   = count_dec[IDX_W-1:0];
  assign free_slot = count[IDX_W-1:0];
  assign scan_prev = scan_idx - IDX_W'(1);
  assign hit_next  = PTR_W'(scan_idx) + PTR_W'(1);
  assign mv_next1  = PTR_W'(mv_idx) + PTR_W'(1);
  assign mv_next2  = PTR_W'(mv_idx) + PTR_W'(2);
  assign free_ok   = cfg.heap_enable && (uaddr != '0) && (count != CNT_FULL);
  assign rd_base   = ram_rdata[ENTRY_W-1:SIZE_W];
  assign rd_bytes  = ram_rdata[SIZE_W-1:0];

  // Each state puts at most one operation on the shared adder.
  always_comb begin
    alu_req.sub = 1'b0;
    alu_req.a   = '0;
    alu_req.b   = '0;
    case (state)
      ST_DECODE: begin
        if (cmd == CMD_FREE) begin
          alu_req.sub = 1'b1;
          alu_req.a   = {1'b0, uaddr};
          alu_req.b   = HDR_OPND;
        end else begin
          alu_req.a = OPND_W'(req);
          alu_req.b = ROUND_OPND;
        end
      end
      ST_SCAN: begin
        alu_req.sub = 1'b1;
        alu_req.a   = OPND_W'(rd_bytes);
        alu_req.b   = OPND_W'(needed);
      end
      ST_REUSE: begin
        alu_req.a = {1'b0, blk_base};
        alu_req.b = HDR_OPND;
      end
      ST_BUMP_ADD: begin
        alu_req.a = {1'b0, bump};
        alu_req.b = OPND_W'(needed);
      end
      ST_BUMP_CHK: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, cfg.heap_limit};
        alu_req.b   = bump_sum;
      end
      ST_BUMP_GRANT: begin
        alu_req.a = {1'b0, bump};
        alu_req.b = HDR_OPND;
      end
      default: begin
        alu_req.sub = 1'b0;
      end
    endcase
  end

  // The read address always runs one entry ahead of the entry being used.
  always_comb begin
    ram_we    = (state == ST_SHIFT) ||
                ((state == ST_DECODE) && (cmd == CMD_FREE) && free_ok);
    ram_waddr = (state == ST_SHIFT) ? mv_idx : free_slot;
    ram_wdata = (state == ST_SHIFT) ? ram_rdata : {alu_res.result[ADDR_W-1:0], fsize};
    case (state)
      ST_DECODE: ram_raddr = top_idx;
      ST_SCAN:   ram_raddr = scan_prev;
      ST_REUSE:  ram_raddr = hit_next[IDX_W-1:0];
      ST_SHIFT:  ram_raddr = mv_next2[IDX_W-1:0];
      default:   ram_raddr = scan_idx;
    endcase
  end

  ffa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(FREE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ffa_alu u_alu (
    .req(alu_req),
    .res(alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      count <= '0;
      bump  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd   <= command;
            req   <= request_size;
            uaddr <= user_address;
            fsize <= freed_block_size;
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (cmd == CMD_FREE) begin
            done            <= 1'b1;
            granted_address <= '0;
            granted_size    <= '0;
            if (!cfg.heap_enable || (uaddr == '0)) begin
              status <= STAT_IGNORED;
            end else if (count == CNT_FULL) begin
              status <= STAT_FULL;
            end else begin
              status <= STAT_FREED;
              count  <= count + CNT_W'(1);
            end
            state <= ST_IDLE;
          end else if (!cfg.heap_enable) begin
            done            <= 1'b1;
            granted_address <= '0;
            granted_size    <= '0;
            status          <= STAT_DISABLED;
            state           <= ST_IDLE;
          end else begin
            needed <= {alu_res.result[SIZE_W-1:3], 3'b000};
            if (count == '0) begin
              state <= ST_BUMP_ADD;
            end else begin
              scan_idx <= top_idx;
              state    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (alu_res.ge) begin
            blk_base  <= rd_base;
            blk_bytes <= rd_bytes;
            state     <= ST_REUSE;
          end else if (scan_idx == '0) begin
            state <= ST_BUMP_ADD;
          end else begin
            scan_idx <= scan_prev;
          end
        end
        ST_REUSE: begin
          done            <= 1'b1;
          granted_address <= alu_res.result[ADDR_W-1:0];
          granted_size    <= blk_bytes;
          status          <= STAT_REUSED;
          count           <= count_dec;
          mv_idx          <= scan_idx;
          // Taking the newest entry leaves nothing above it to move down.
          if (hit_next == PTR_W'(count)) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (mv_next1 == PTR_W'(count)) begin
            state <= ST_IDLE;
          end else begin
            mv_idx <= mv_next1[IDX_W-1:0];
          end
        end
        ST_BUMP_ADD: begin
          bump_sum <= alu_res.result;
          state    <= ST_BUMP_CHK;
        end
        ST_BUMP_CHK: begin
          if (!alu_res.ge) begin
            done            <= 1'b1;
            granted_address <= '0;
            granted_size    <= '0;
            status          <= STAT_NOMEM;
            state           <= ST_IDLE;
          end else begin
            state <= ST_BUMP_GRANT;
          end
        end
        ST_BUMP_GRANT: begin
          done            <= 1'b1;
          granted_address <= alu_res.result[ADDR_W-1:0];
          granted_size    <= needed;
          status          <= STAT_BUMP;
          bump            <= bump_sum[ADDR_W-1:0];
          state           <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg.reload) begin
        count <= '0;
        bump  <= cfg.reload_base;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) != ST_IDLE))
    else $error("result strobe without a request in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("free table count exceeds its depth");

  a_reuse_pops: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_REUSED) && !$past(cfg.reload)) |-> (count == $past(count_dec)))
    else $error("reused block did not leave the table");

  a_free_pushes: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_FREED) && !$past(cfg.reload))
      |-> (count == $past(count) + CNT_W'(1)))
    else $error("freed block was not added to the table");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_REUSED) && (status != STAT_BUMP))
      |-> ((granted_address == '0) && (granted_size == '0)))
    else $error("non-grant result carries an address or size");
`endif

endmodule

FILE: hw/rtl/first_fit_free_list_allocator_top.sv
// Top level of the first-fit free-list allocator: APB register file and core.
// Depends on ffa_pkg and ffa_ctrl (which uses ffa_ram and ffa_alu).
//
//  channel   | signals                                            | transfer
//  ----------+----------------------------------------------------+--------------------------
//  request   | start, busy, command, request_size, user_address,  | start high, busy low
//            | freed_block_size                                   |
//  result    | done, granted_address, granted_size, status        | done high, one cycle
//  config    | psel, penable, pwrite, paddr, pwdata, prdata,      | psel, penable, pwrite,
//            | pready                                             | pready high
//
// Registers sit at byte offsets 0 (heap_start), 8 (heap_limit) and 16 (heap_enable).
// A free, or any request while disabled, completes in the decode state. An allocate
// decodes, then examines any table entries newest first, then either takes the bump path
// (add, limit check, grant; it stops after the check when the heap limit would be
// passed) or, on reuse, grants and then moves each newer entry down by one slot.
// The single read port of the table memory and the one shared adder set this sequence.
// Reset clears the table count, the bump pointer and the registers; the result strobe
// cannot be held off by the receiver.
module first_fit_free_list_allocator_top #(
  parameter int FREE_DEPTH   = 16,
  parameter int HEADER_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ffa_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ffa_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ffa_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  logic [ffa_pkg::REQ_W-1:0]       request_size,
  input  logic [ffa_pkg::ADDR_W-1:0]      user_address,
  input  logic [ffa_pkg::SIZE_W-1:0]      freed_block_size,
  output logic                            done,
  output logic [ffa_pkg::ADDR_W-1:0]      granted_address,
  output logic [ffa_pkg::SIZE_W-1:0]      granted_size,
  output logic [2:0]                      status
);
  import ffa_pkg::*;

  localparam logic [1:0] REG_HEAP_START  = 2'd0;
  localparam logic [1:0] REG_HEAP_LIMIT  = 2'd1;
  localparam logic [1:0] REG_HEAP_ENABLE = 2'd2;
  localparam logic [1:0] REG_UNMAPPED    = 2'd3;

  logic [ADDR_W-1:0] heap_start;
  logic [ADDR_W-1:0] heap_limit;
  logic              heap_enable;
  logic [1:0]        reg_sel;
  logic              wr;
  logic              wr_known;
  cfg_t              cfg;

  assign pready   = 1'b1;
  assign reg_sel  = paddr[CFG_ADDR_W-1:3];
  assign wr       = psel && penable && pwrite && pready;
  assign wr_known = wr && (reg_sel != REG_UNMAPPED);

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start  <= '0;
      heap_limit  <= '0;
      heap_enable <= 1'b0;
    end else if (wr) begin
      case (reg_sel)
        REG_HEAP_START:  heap_start  <= pwdata[ADDR_W-1:0];
        REG_HEAP_LIMIT:  heap_limit  <= pwdata[ADDR_W-1:0];
        REG_HEAP_ENABLE: heap_enable <= pwdata[0];
        default:         heap_enable <= heap_enable;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HEAP_START:  prdata = CFG_DATA_W'(heap_start);
      REG_HEAP_LIMIT:  prdata = CFG_DATA_W'(heap_limit);
      REG_HEAP_ENABLE: prdata = CFG_DATA_W'(heap_enable);
      default:         prdata = '0;
    endcase
  end

  // On a heap_start write the core reloads from the new value; heap_limit and heap_enable reach it as registered.
  assign cfg.heap_limit  = heap_limit;
  assign cfg.heap_enable = heap_enable;
  assign cfg.reload      = wr_known;
  assign cfg.reload_base = (reg_sel == REG_HEAP_START) ? pwdata[ADDR_W-1:0] : heap_start;

  ffa_ctrl #(
    .FREE_DEPTH  (FREE_DEPTH),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .request_size    (request_size),
    .user_address    (user_address),
    .freed_block_size(freed_block_size),
    .done            (done),
    .granted_address (granted_address),
    .granted_size    (granted_size),
    .status          (status)
  );

endmodule
